/* sv/aid_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aid_pkg - shared types and constants for the array insert/delete block
// Command and status codes, request/result structs and the per-cell control
// bundle broadcast from the top level to the row of storage cells.
// ----------------------------------------------------------------------------
package aid_pkg;

	// storage geometry
	localparam int DEPTH  = 64;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = 7;
	localparam int DATA_W = 32;

	// capacity register reset value
	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

	// command codes
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;
	localparam logic [1:0] CMD_READ   = 2'd2;
	localparam logic [1:0] CMD_NOP    = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_RANGE   = 2'd2;
	localparam logic [1:0] ST_MISSING = 2'd3;

	// one request transaction
	typedef struct packed {
		logic [1:0]               command;
		logic signed [DATA_W-1:0] value;
		logic [CNT_W-1:0]         position;
	} req_t;

	// one result transaction
	typedef struct packed {
		logic [CNT_W-1:0]         count;
		logic [1:0]               status;
		logic signed [DATA_W-1:0] read_value;
	} rsp_t;

	// control broadcast to every cell
	typedef struct packed {
		logic                     capture;
		logic signed [DATA_W-1:0] cmp_value;
		logic [CNT_W-1:0]         cmp_pos;
		logic                     ins;
		logic                     del;
		logic signed [DATA_W-1:0] ins_value;
		logic [CNT_W-1:0]         ins_pos;
		logic [CNT_W-1:0]         count;
	} cell_ctl_t;

endpackage

/* sv/aid_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aid_cell - one storage slot of the packed array
// Holds one entry, registers its own match and read tap for the pending
// transaction, and shifts from its left or right neighbor on insert/delete.
// ----------------------------------------------------------------------------
module aid_cell (
	input  logic                              clk,
	input  logic [aid_pkg::IDX_W-1:0]         idx,
	input  aid_pkg::cell_ctl_t                ctl,
	input  logic                              hit,
	input  logic signed [aid_pkg::DATA_W-1:0] left,
	input  logic signed [aid_pkg::DATA_W-1:0] right,
	output logic signed [aid_pkg::DATA_W-1:0] entry,
	output logic                              match_s1,
	output logic signed [aid_pkg::DATA_W-1:0] rdtap_s1
);
	import aid_pkg::*;

	logic signed [DATA_W-1:0] entry_q;
	logic [CNT_W-1:0]         slot_num;
	logic                     occupied;

	// 1-based slot number of this cell
	assign slot_num = CNT_W'(idx) + CNT_W'(1);
	assign occupied = CNT_W'(idx) < ctl.count;
	assign entry    = entry_q;

	// compare/read taps on accept, shift on commit
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			match_s1 <= occupied && (entry_q == ctl.cmp_value);
			rdtap_s1 <= (slot_num == ctl.cmp_pos) ? entry_q : '0;
		end
		if (ctl.ins) begin
			if (slot_num == ctl.ins_pos)
				entry_q <= ctl.ins_value;
			else if (slot_num > ctl.ins_pos)
				entry_q <= left;
		end else if (ctl.del && hit) begin
			entry_q <= right;
		end
	end

endmodule

/* sv/array_insert_delete.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_insert_delete - packed array with positional insert, delete by value
// Keeps up to DEPTH signed 32-bit entries in a row of shift cells with a
// count; supports insert at a 1-based position, delete of first match, read.
// ----------------------------------------------------------------------------
// On accept each cell registers its compare result and read tap and the
// block enters S_EXEC; in S_EXEC the row shifts, the count updates and the
// result is registered. busy is high while the block is in S_EXEC, so no
// new transaction is accepted while one is in S_EXEC; a new one can be
// accepted in the same cycle the previous result is presented. done is high
// for exactly one cycle with the result; the receiver cannot stall it. The
// capacity register is written through the cfg channel, which is always ready.
module array_insert_delete (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  aid_pkg::req_t                request,
	output logic                         done,
	output aid_pkg::rsp_t                result,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [aid_pkg::CNT_W-1:0]    cfg_data
);
	import aid_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t                   state_q;
	req_t                     req_s1;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         capacity_q;
	logic                     done_q;
	rsp_t                     result_q;

	cell_ctl_t                ctl;
	logic                     accept;
	logic signed [DATA_W-1:0] entry_w [DEPTH];
	logic signed [DATA_W-1:0] rdtap_w [DEPTH];
	logic [DEPTH-1:0]         match_w;
	logic [DEPTH-1:0]         hit_w;

	logic [CNT_W-1:0]         limit;
	logic                     found;
	logic signed [DATA_W-1:0] rd_word;
	logic                     ins_ok;
	logic                     del_ok;
	rsp_t                     rsp_next;
	logic [CNT_W-1:0]         count_next;

	assign accept    = start && !busy;
	assign busy      = (state_q == S_EXEC);
	assign done      = done_q;
	assign result    = result_q;
	assign cfg_ready = 1'b1;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			capacity_q <= CAP_RESET;
		else if (cfg_valid && cfg_ready)
			capacity_q <= cfg_data;
	end

	// latched request
	always_ff @(posedge clk) begin
		if (accept)
			req_s1 <= request;
	end

	// effective limit and combined cell taps
	assign limit = (capacity_q < CNT_W'(DEPTH)) ? capacity_q : CNT_W'(DEPTH);
	assign found = |match_w;

	always_comb begin
		rd_word = '0;
		for (int i = 0; i < DEPTH; i++)
			rd_word = rd_word | rdtap_w[i];
	end

	// commit decision
	always_comb begin
		rsp_next   = '0;
		count_next = count_q;
		ins_ok     = 1'b0;
		del_ok     = 1'b0;
		rsp_next.status = ST_OK;
		unique case (req_s1.command)
			CMD_INSERT: begin
				if (count_q >= limit)
					rsp_next.status = ST_FULL;
				else if (req_s1.position == '0 ||
				         {1'b0, req_s1.position} > ({1'b0, count_q} + (CNT_W+1)'(1)))
					rsp_next.status = ST_RANGE;
				else begin
					ins_ok     = 1'b1;
					count_next = count_q + CNT_W'(1);
				end
			end
			CMD_DELETE: begin
				if (found) begin
					del_ok     = 1'b1;
					count_next = count_q - CNT_W'(1);
				end else begin
					rsp_next.status = ST_MISSING;
				end
			end
			CMD_READ: begin
				if (req_s1.position != '0 && req_s1.position <= count_q)
					rsp_next.read_value = rd_word;
				else
					rsp_next.status = ST_RANGE;
			end
			default: rsp_next.status = ST_OK;
		endcase
		rsp_next.count = count_next;
	end

	// control broadcast to the cell row
	always_comb begin
		ctl.capture   = accept;
		ctl.cmp_value = request.value;
		ctl.cmp_pos   = request.position;
		ctl.ins       = busy && ins_ok;
		ctl.del       = busy && del_ok;
		ctl.ins_value = req_s1.value;
		ctl.ins_pos   = req_s1.position;
		ctl.count     = count_q;
	end

	// row of cells; a cell at or past the first match pulls from the right
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [DATA_W-1:0] left_w;
		logic signed [DATA_W-1:0] right_w;

		assign hit_w[i] = |match_w[i:0];

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = entry_w[i-1];
		end
		if (i == DEPTH-1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = entry_w[i+1];
		end

		aid_cell u_cell (
			.clk      (clk),
			.idx      (IDX_W'(i)),
			.ctl      (ctl),
			.hit      (hit_w[i]),
			.left     (left_w),
			.right    (right_w),
			.entry    (entry_w[i]),
			.match_s1 (match_w[i]),
			.rdtap_s1 (rdtap_w[i])
		);
	end

	// control state, count and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start)
						state_q <= S_EXEC;
				end
				S_EXEC: begin
					count_q  <= count_next;
					result_q <= rsp_next;
					done_q   <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* tb/array_insert_delete_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_insert_delete_tb - self-checking bench for the array insert/delete block
// A clocked driver issues queued commands and a clocked monitor keeps a shadow
// array that predicts every result. Runs directed corner cases, then random
// traffic over several capacity settings and sender idle rates.
// ----------------------------------------------------------------------------
module array_insert_delete_tb;
	import aid_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	req_t               request;
	logic               done;
	rsp_t               result;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CNT_W-1:0]   cfg_data;

	// shadow of the block state
	logic signed [DATA_W-1:0] shadow_vals [DEPTH];
	logic [CNT_W-1:0]         shadow_count = '0;
	logic [CNT_W-1:0]         shadow_cap   = CAP_RESET;

	req_t pending_ops [$];
	rsp_t want_rsp [$];
	rsp_t mon_rsp;
	logic taken    = 1'b0;
	int   idle_pct = 0;
	int   err_cnt  = 0;

	array_insert_delete u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// clock, 20 ns period
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// apply one command to the shadow array and work out its result
	task automatic apply_array_op(input req_t q, output rsp_t r);
		logic [CNT_W-1:0] lim;
		logic             found;
		int               hit;
		r.status     = ST_OK;
		r.read_value = '0;
		lim = (shadow_cap < DEPTH) ? shadow_cap : CNT_W'(DEPTH);
		case (q.command)
			CMD_INSERT: begin
				if (shadow_count >= lim) begin
					r.status = ST_FULL;
				end else if (q.position < 1 || q.position > shadow_count + 1) begin
					r.status = ST_RANGE;
				end else begin
					for (int k = shadow_count; k >= q.position; k--)
						shadow_vals[k] = shadow_vals[k-1];
					shadow_vals[q.position-1] = q.value;
					shadow_count = shadow_count + 1'b1;
				end
			end
			CMD_DELETE: begin
				found = 1'b0;
				hit   = 0;
				for (int k = 0; k < shadow_count; k++) begin
					if (!found && shadow_vals[k] == q.value) begin
						found = 1'b1;
						hit   = k;
					end
				end
				if (!found) begin
					r.status = ST_MISSING;
				end else begin
					for (int k = hit; k + 1 < shadow_count; k++)
						shadow_vals[k] = shadow_vals[k+1];
					shadow_count = shadow_count - 1'b1;
				end
			end
			CMD_READ: begin
				if (q.position >= 1 && q.position <= shadow_count)
					r.read_value = shadow_vals[q.position-1];
				else
					r.status = ST_RANGE;
			end
			default: begin
			end
		endcase
		r.count = shadow_count;
	endtask

	// driver: a new transaction goes out at the falling edge after the last one was taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (!start || taken) begin
				if (pending_ops.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
					request <= pending_ops.pop_front();
					start   <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: check results, track capacity writes, predict accepted commands
	always @(posedge clk) begin
		if (arst_n) begin
			// result check
			if (done) begin
				if (want_rsp.size() == 0) begin
					$display("%0t: unexpected result count=%0d status=%0d read_value=%0d",
						$time, result.count, result.status, result.read_value);
					err_cnt++;
				end else begin
					mon_rsp = want_rsp.pop_front();
					if (result.count !== mon_rsp.count || result.status !== mon_rsp.status ||
						result.read_value !== mon_rsp.read_value) begin
						$display("%0t: mismatch expected count=%0d status=%0d read_value=%0d",
							$time, mon_rsp.count, mon_rsp.status, mon_rsp.read_value);
						$display("%0t:          actual   count=%0d status=%0d read_value=%0d",
							$time, result.count, result.status, result.read_value);
						err_cnt++;
					end
				end
			end
			// capacity write
			if (cfg_valid && cfg_ready)
				shadow_cap = cfg_data;
			// command accept
			taken = start && !busy;
			if (taken) begin
				apply_array_op(request, mon_rsp);
				want_rsp.push_back(mon_rsp);
			end
		end
	end

	task automatic push_op(input logic [1:0] cmd, input logic signed [DATA_W-1:0] val,
		input logic [CNT_W-1:0] pos);
		req_t q;
		q.command  = cmd;
		q.value    = val;
		q.position = pos;
		pending_ops.push_back(q);
	endtask

	// value mix: small values give duplicates, plus extremes and full-range noise
	function automatic logic signed [DATA_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return $signed($urandom_range(0, 8)) - 4;
		if (r < 50) begin
			case ($urandom_range(0, 3))
				0: return 32'sh7fffffff;
				1: return 32'sh80000000;
				2: return 32'sh0;
				default: return -32'sh1;
			endcase
		end
		return $urandom;
	endfunction

	// random traffic in short bursts, shaped from a snapshot of the shadow array
	task automatic queue_ops(input int total, input int ins_pct, input int del_pct);
		int left;
		int burst;
		int r;
		int n_now;
		logic signed [DATA_W-1:0] v;
		logic [CNT_W-1:0]         p;
		left = total;
		while (left > 0) begin
			while (pending_ops.size() > 1)
				@(posedge clk);
			burst = $urandom_range(1, 16);
			if (burst > left)
				burst = left;
			left -= burst;
			for (int i = 0; i < burst; i++) begin
				n_now = shadow_count;
				r = $urandom_range(0, 99);
				if (r < ins_pct) begin
					if ($urandom_range(0, 9) == 0)
						p = $urandom_range(0, 127);
					else
						p = $urandom_range(1, n_now + 1);
					push_op(CMD_INSERT, pick_value(), p);
				end else if (r < ins_pct + del_pct) begin
					if (n_now > 0 && $urandom_range(0, 99) < 70)
						v = shadow_vals[$urandom_range(0, n_now - 1)];
					else
						v = pick_value();
					push_op(CMD_DELETE, v, $urandom_range(0, 127));
				end else if (r < 96) begin
					if (n_now > 0 && $urandom_range(0, 99) < 85)
						p = $urandom_range(1, n_now);
					else
						p = $urandom_range(0, 127);
					push_op(CMD_READ, $urandom, p);
				end else begin
					push_op(CMD_NOP, $urandom, $urandom_range(0, 127));
				end
			end
		end
	endtask

	// wait until every queued transaction has been taken and answered
	task automatic wait_idle();
		while (pending_ops.size() != 0 || start || want_rsp.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CNT_W-1:0] cap);
		wait_idle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= cap;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// stimulus sequence
	initial begin
		int spin;
		arst_n    = 1'b0;
		start     = 1'b0;
		request   = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		for (int k = 0; k < DEPTH; k++)
			shadow_vals[k] = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed corner cases at reset capacity
		push_op(CMD_READ,   0, 1);               // read of empty array
		push_op(CMD_DELETE, 5, 0);               // delete with nothing stored
		push_op(CMD_INSERT, 3, 0);               // position zero
		push_op(CMD_INSERT, 3, 2);               // past the end of an empty array
		push_op(CMD_INSERT, 32'sh7fffffff, 1);   // insert into empty array
		push_op(CMD_INSERT, 32'sh80000000, 1);   // insert at the front
		push_op(CMD_INSERT, -1, 3);              // append at count+1
		push_op(CMD_INSERT, 7, 2);
		push_op(CMD_INSERT, 7, 4);               // duplicate value
		push_op(CMD_INSERT, 1, 7);               // one past count+1
		push_op(CMD_INSERT, 0, 127);
		push_op(CMD_READ,   0, 1);
		push_op(CMD_READ,   0, 5);
		push_op(CMD_READ,   0, 6);               // read past count
		push_op(CMD_READ,   0, 0);
		push_op(CMD_READ,   0, 127);
		push_op(CMD_DELETE, 7, 0);               // removes only the first match
		push_op(CMD_READ,   0, 2);
		push_op(CMD_READ,   0, 3);
		push_op(CMD_DELETE, 12345, 0);           // no match
		push_op(CMD_DELETE, 32'sh80000000, 0);   // first entry
		push_op(CMD_DELETE, -1, 0);              // last entry
		push_op(CMD_NOP,    $urandom, $urandom_range(0, 127));
		push_op(CMD_READ,   0, 1);
		queue_ops(100, 65, 15);

		// capacity above depth, fill to the top
		write_capacity(7'd127);
		idle_pct = 61;
		queue_ops(100, 80, 8);

		// capacity below the count: inserts refused while draining
		write_capacity(7'd10);
		idle_pct = 0;
		queue_ops(80, 25, 60);

		// zero capacity: full takes precedence over a bad position
		write_capacity(7'd0);
		idle_pct = 33;
		push_op(CMD_INSERT, 9, 0);
		push_op(CMD_INSERT, 9, 127);
		queue_ops(60, 35, 50);

		// capacity of one
		write_capacity(7'd1);
		idle_pct = 61;
		queue_ops(50, 50, 30);

		// back to depth, mixed traffic
		write_capacity(7'd64);
		idle_pct = 33;
		queue_ops(40, 55, 30);

		// drain and settle
		spin = 0;
		while ((pending_ops.size() != 0 || start || want_rsp.size() != 0) && spin < 2000) begin
			@(posedge clk);
			spin++;
		end
		repeat (6) @(posedge clk);
		if (want_rsp.size() != 0 || pending_ops.size() != 0) begin
			$display("%0t: %0d expected results never arrived, %0d commands never taken",
				$time, want_rsp.size(), pending_ops.size());
			err_cnt++;
		end
		if (err_cnt == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("%0t: timeout", $time);
		$display("*** FAILED ***");
		$finish;
	end

endmodule
